// ===== rtl/core/ocp_pkg.sv =====
// shared types, constants and helper functions of the orbit camera position core
// no dependencies; used by the channel interfaces and the top level
`default_nettype none

package ocp_pkg;

  localparam int FIELD_W    = 10;
  localparam int DIST_W     = 10;
  localparam int ANGLE_W    = 9;
  localparam int OUT_W      = 19;
  localparam int OUT_FRAC   = 8;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;
  localparam int ROM_IDX_W  = 7;
  localparam int ROM_LAST   = 90;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DISTANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DISTANCE = 1'b1;

  localparam logic [DIST_W-1:0] MIN_DISTANCE_RST = 10'd1;
  localparam logic [DIST_W-1:0] MAX_DISTANCE_RST = 10'd500;

  localparam logic [ANGLE_W-1:0] DEG_90  = 9'd90;
  localparam logic [ANGLE_W-1:0] DEG_180 = 9'd180;
  localparam logic [ANGLE_W-1:0] DEG_270 = 9'd270;
  localparam logic [ANGLE_W-1:0] DEG_360 = 9'd360;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MUL_RCA,
    ST_MUL_RSA,
    ST_MUL_X,
    ST_MUL_Y,
    ST_DONE
  } ocp_state_e;

  typedef struct packed {
    logic                 neg;
    logic [ROM_IDX_W-1:0] idx;
  } ocp_trig_idx_t;

  // elaboration-time quarter-wave entry: taylor series in q2.30
  function automatic logic [63:0] rom_sin_entry(int unsigned k, int unsigned fb);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] half;
    if (k >= ROM_LAST) begin
      return 64'd1 << fb;
    end
    x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd20;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd42;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd72;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd110;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd156;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd210;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd272;
    sum  = sum + term;
    term = ((term * x2) >> 30) / 64'd342;
    sum  = sum - term;
    term = ((term * x2) >> 30) / 64'd420;
    sum  = sum + term;
    half = 64'd1 << (29 - fb);
    return (sum + half) >> (30 - fb);
  endfunction

  function automatic logic [ANGLE_W-1:0] wrap_angle(logic [ANGLE_W-1:0] a,
                                                    logic signed [FIELD_W-1:0] d);
    logic signed [ANGLE_W+1:0] s;
    logic signed [ANGLE_W+1:0] r;
    s = signed'({2'b00, a}) + (ANGLE_W+2)'(d);
    if (s < -11'sd360) begin
      r = s + 11'sd720;
    end else if (s < 11'sd0) begin
      r = s + 11'sd360;
    end else if (s >= 11'sd720) begin
      r = s - 11'sd720;
    end else if (s >= 11'sd360) begin
      r = s - 11'sd360;
    end else begin
      r = s;
    end
    return r[ANGLE_W-1:0];
  endfunction

  function automatic logic [ANGLE_W-1:0] cos_angle(logic [ANGLE_W-1:0] a);
    if (a >= DEG_270) begin
      return a - DEG_270;
    end
    return a + DEG_90;
  endfunction

  // quadrant folding of a 0..359 angle onto the quarter-wave table
  function automatic ocp_trig_idx_t trig_index(logic [ANGLE_W-1:0] a);
    ocp_trig_idx_t t;
    logic [ANGLE_W-1:0] k;
    if (a <= DEG_90) begin
      k     = a;
      t.neg = 1'b0;
    end else if (a <= DEG_180) begin
      k     = DEG_180 - a;
      t.neg = 1'b0;
    end else if (a <= DEG_270) begin
      k     = a - DEG_180;
      t.neg = 1'b1;
    end else begin
      k     = DEG_360 - a;
      t.neg = 1'b1;
    end
    t.idx = k[ROM_IDX_W-1:0];
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ocp_req_if.sv =====
// request channel of the orbit camera position core: three signed deltas
// depends on ocp_pkg
`default_nettype none

interface ocp_req_if;
  import ocp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [FIELD_W-1:0] delta_azimuth;
  logic signed [FIELD_W-1:0] delta_elevation;
  logic signed [FIELD_W-1:0] delta_distance;

  modport source (
    output valid, delta_azimuth, delta_elevation, delta_distance,
    input  ready
  );

  modport sink (
    input  valid, delta_azimuth, delta_elevation, delta_distance,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/ocp_res_if.sv =====
// result channel of the orbit camera position core: camera position x, y, z
// depends on ocp_pkg
`default_nettype none

interface ocp_res_if;
  import ocp_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] pos_x;
  logic signed [OUT_W-1:0] pos_y;
  logic signed [OUT_W-1:0] pos_z;

  modport source (
    output valid, pos_x, pos_y, pos_z,
    input  ready
  );

  modport sink (
    input  valid, pos_x, pos_y, pos_z,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/core/orbit_camera_position_core.sv =====
// orbit camera position core: angle and distance update, table sine and cosine,
// and one shared multiplier that forms the spherical-to-cartesian products
// depends on ocp_pkg, ocp_req_if and ocp_res_if
//
// usage:
//   req_i carries delta_azimuth, delta_elevation and delta_distance; each request
//   updates the two wrapped angles and, when the distance delta is non-zero and
//   the new distance lies strictly between the bounds, the distance.
//   res_o returns one position (x, y, z, 8 fraction bits) for every request.
//   cfg_we_i/cfg_idx_i/cfg_data_i write min_distance (index 0) and max_distance
//   (index 1); write them only while the core is idle, which the core does not enforce.
//   steps: one idle step to take the request, one for the table lookup, four
//   products one after another through the single multiplier and one to load
//   the output register; a new request is taken only once the last step is done.
//   reset clears both angles and the distance, sets the bounds to 1 and 500
//   and empties the output register.
//   when the receiver stalls the result stays in the output register; one more
//   request is taken and worked on, and it waits in its last step until the
//   output register is free.
`default_nettype none

module orbit_camera_position_core #(
  parameter int TRIG_FRAC_BITS = 15
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [ocp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [ocp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ocp_req_if.sink                               req_i,
  ocp_res_if.source                             res_o
);
  import ocp_pkg::*;

  localparam int TW    = TRIG_FRAC_BITS + 1;
  localparam int AW    = DIST_W + TW;
  localparam int PW    = AW + TW;
  localparam int ZSH   = TRIG_FRAC_BITS - OUT_FRAC;
  localparam int XYSH  = 2 * TRIG_FRAC_BITS - OUT_FRAC;
  localparam logic [PW-1:0] Z_HALF  = (PW'(1) << ZSH) >> 1;
  localparam logic [PW-1:0] XY_HALF = (PW'(1) << XYSH) >> 1;

  // quarter-wave sine table
  logic [TW-1:0] sin_rom [0:ROM_LAST];

  for (genvar g = 0; g <= ROM_LAST; g++) begin : g_rom
    assign sin_rom[g] = TW'(rom_sin_entry(g, TRIG_FRAC_BITS));
  end

  ocp_state_e state_q, state_d;

  logic [DIST_W-1:0]  min_q, max_q;
  logic [ANGLE_W-1:0] angle_a_q, angle_b_q;
  logic [DIST_W-1:0]  radius_q;

  logic [TW-1:0] sa_q, ca_q, sb_q, cb_q;
  logic          nsa_q, nca_q, nsb_q, ncb_q;
  logic [PW-1:0] mul_q;
  logic [AW-1:0] pca_q;
  logic signed [OUT_W-1:0] x_q, z_q;

  logic                    out_valid_q;
  logic signed [OUT_W-1:0] out_x_q, out_y_q, out_z_q;

  logic req_take;
  logic out_load;
  logic out_free;

  logic signed [DIST_W+1:0] cand;
  logic                     radius_ok;

  ocp_trig_idx_t ti_sa, ti_ca, ti_sb, ti_cb;

  logic [AW-1:0] mul_a;
  logic [TW-1:0] mul_b;
  logic [PW-1:0] mul_p;
  logic          mul_en;

  logic [PW-1:0]           z_sum, xy_sum;
  logic [OUT_W-1:0]        z_mag, xy_mag;
  logic signed [OUT_W-1:0] z_val, x_val, y_val;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_free = !out_valid_q || res_o.ready;

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    out_load    = 1'b0;
    mul_en      = 1'b0;
    case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          state_d = ST_TRIG;
        end
      end
      ST_TRIG: begin
        state_d = ST_MUL_RCA;
      end
      ST_MUL_RCA: begin
        mul_en  = 1'b1;
        state_d = ST_MUL_RSA;
      end
      ST_MUL_RSA: begin
        mul_en  = 1'b1;
        state_d = ST_MUL_X;
      end
      ST_MUL_X: begin
        mul_en  = 1'b1;
        state_d = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        mul_en  = 1'b1;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign req_take = req_i.valid && req_i.ready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_DISTANCE_RST;
      max_q <= MAX_DISTANCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MIN_DISTANCE: min_q <= cfg_data_i;
        CFG_MAX_DISTANCE: max_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // camera state update
  assign cand      = signed'({2'b00, radius_q}) + (DIST_W+2)'(req_i.delta_distance);
  assign radius_ok = (req_i.delta_distance != '0)
                     && (cand > signed'({2'b00, min_q}))
                     && (cand < signed'({2'b00, max_q}));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_a_q <= '0;
      angle_b_q <= '0;
      radius_q  <= '0;
    end else if (req_take) begin
      angle_a_q <= wrap_angle(angle_a_q, req_i.delta_azimuth);
      angle_b_q <= wrap_angle(angle_b_q, req_i.delta_elevation);
      if (radius_ok) begin
        radius_q <= cand[DIST_W-1:0];
      end
    end
  end

  // table lookup
  assign ti_sa = trig_index(angle_a_q);
  assign ti_ca = trig_index(cos_angle(angle_a_q));
  assign ti_sb = trig_index(angle_b_q);
  assign ti_cb = trig_index(cos_angle(angle_b_q));

  always_ff @(posedge clk_i) begin
    if (state_q == ST_TRIG) begin
      sa_q  <= sin_rom[ti_sa.idx];
      ca_q  <= sin_rom[ti_ca.idx];
      sb_q  <= sin_rom[ti_sb.idx];
      cb_q  <= sin_rom[ti_cb.idx];
      nsa_q <= ti_sa.neg;
      nca_q <= ti_ca.neg;
      nsb_q <= ti_sb.neg;
      ncb_q <= ti_cb.neg;
    end
  end

  // shared multiplier
  always_comb begin
    mul_a = pca_q;
    mul_b = '0;
    case (state_q)
      ST_MUL_RCA: begin
        mul_a = AW'(radius_q);
        mul_b = ca_q;
      end
      ST_MUL_RSA: begin
        mul_a = AW'(radius_q);
        mul_b = sa_q;
      end
      ST_MUL_X: mul_b = sb_q;
      ST_MUL_Y: mul_b = cb_q;
      default: begin
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // rounding to nearest, ties away from zero, on the magnitude
  assign z_sum  = mul_q + Z_HALF;
  assign xy_sum = mul_q + XY_HALF;
  assign z_mag  = OUT_W'(z_sum >> ZSH);
  assign xy_mag = OUT_W'(xy_sum >> XYSH);
  assign z_val  = nsa_q ? -signed'(z_mag) : signed'(z_mag);
  assign x_val  = (nca_q ^ nsb_q) ? -signed'(xy_mag) : signed'(xy_mag);
  assign y_val  = (nca_q ^ ncb_q) ? -signed'(xy_mag) : signed'(xy_mag);

  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      mul_q <= mul_p;
    end
    if (state_q == ST_MUL_RSA) begin
      pca_q <= mul_q[AW-1:0];
    end
    if (state_q == ST_MUL_X) begin
      z_q <= z_val;
    end
    if (state_q == ST_MUL_Y) begin
      x_q <= x_val;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q <= x_q;
      out_y_q <= y_val;
      out_z_q <= z_q;
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.pos_x = out_x_q;
  assign res_o.pos_y = out_y_q;
  assign res_o.pos_z = out_z_q;

  // checks
  a_angles_wrapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    angle_a_q < DEG_360 && angle_b_q < DEG_360)
    else $error("angle out of range");

  a_radius_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TRIG && radius_q != $past(radius_q))
      |-> (radius_q > min_q && radius_q < max_q))
    else $error("radius moved outside bounds");

  a_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE && out_valid_q && !res_o.ready) |=> state_q == ST_DONE)
    else $error("result overwrote an undelivered output");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_take |=> !req_i.ready)
    else $error("request taken while busy");

endmodule

`default_nettype wire

// ===== test/orbit_camera_position_core_tb.sv =====
// self-checking testbench of orbit_camera_position_core: random and directed deltas,
// bounds rewritten between phases, positions checked against an in-bench camera model
// depends on ocp_pkg, ocp_req_if, ocp_res_if and the core
`default_nettype none

module orbit_camera_position_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ocp_pkg::*;

  localparam int TRIG_FB    = 15;
  localparam int CLK_PERIOD = 10;

  typedef struct packed {
    logic signed [FIELD_W-1:0] daz;
    logic signed [FIELD_W-1:0] del;
    logic signed [FIELD_W-1:0] ddist;
  } move_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] x;
    logic signed [OUT_W-1:0] y;
    logic signed [OUT_W-1:0] z;
  } pos_t;

  typedef struct packed {
    logic        neg;
    logic [16:0] mag;
  } trig_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  ocp_req_if req_ch ();
  ocp_res_if res_ch ();

  orbit_camera_position_core #(
    .TRIG_FRAC_BITS(TRIG_FB)
  ) u_top (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .req_i     (req_ch),
    .res_o     (res_ch)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  move_t       pending_moves[$];
  pos_t        pos_expected[$];
  logic [16:0] sine_rom[0:90];
  logic [DIST_W-1:0]  bound_lo;
  logic [DIST_W-1:0]  bound_hi;
  logic [ANGLE_W-1:0] az_deg;
  logic [ANGLE_W-1:0] el_deg;
  logic [DIST_W-1:0]  cam_radius;
  int          mismatches;
  int          tx_gap;
  logic [15:0] tx_sent;
  logic        tx_idle_on;
  int          rx_hold;
  int          rx_seen;
  logic        rx_idle_on;

  // taylor series in q2.30, rounded to the table format
  function automatic logic [16:0] taylor_sine(int unsigned k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] acc;
    if (k >= 90) begin
      return 17'(64'd1 << TRIG_FB);
    end
    x    = (64'(k) * PI_Q30 + 64'd90) / 64'd180;
    x2   = (x * x) >> 30;
    term = x;
    acc  = x;
    for (int n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / 64'(4 * n * n + 2 * n);
      acc  = (n % 2 == 1) ? acc - term : acc + term;
    end
    return 17'((acc + (64'd1 << (29 - TRIG_FB))) >> (30 - TRIG_FB));
  endfunction

  function automatic trig_t sine_of(int unsigned deg);
    trig_t t;
    deg = deg % 360;
    t.neg = (deg > 180);
    if (deg <= 90) begin
      t.mag = sine_rom[deg];
    end else if (deg <= 180) begin
      t.mag = sine_rom[180 - deg];
    end else if (deg <= 270) begin
      t.mag = sine_rom[deg - 180];
    end else begin
      t.mag = sine_rom[360 - deg];
    end
    return t;
  endfunction

  // round to nearest, ties away from zero, then apply the sign
  function automatic logic [OUT_W-1:0] round_out(logic [63:0] m, int sh, logic neg);
    m = (m + (64'd1 << (sh - 1))) >> sh;
    if (neg) begin
      m = -m;
    end
    return m[OUT_W-1:0];
  endfunction

  function automatic logic [ANGLE_W-1:0] turn(logic [ANGLE_W-1:0] deg,
                                              logic signed [FIELD_W-1:0] d);
    int t;
    t = (int'(deg) + int'(d)) % 360;
    if (t < 0) begin
      t += 360;
    end
    return ANGLE_W'(t);
  endfunction

  task automatic advance_camera(input logic signed [FIELD_W-1:0] daz,
                                input logic signed [FIELD_W-1:0] del,
                                input logic signed [FIELD_W-1:0] ddist);
    int          cand;
    logic [63:0] d;
    trig_t       sa;
    trig_t       ca;
    trig_t       sb;
    trig_t       cb;
    pos_t        p;
    az_deg = turn(az_deg, daz);
    el_deg = turn(el_deg, del);
    cand = int'(cam_radius) + int'(ddist);
    if (ddist != 0 && cand > int'(bound_lo) && cand < int'(bound_hi)) begin
      cam_radius = DIST_W'(cand);
    end
    d  = 64'(cam_radius);
    sa = sine_of(az_deg);
    ca = sine_of(az_deg + 90);
    sb = sine_of(el_deg);
    cb = sine_of(el_deg + 90);
    p.x = round_out(d * ca.mag * sb.mag, 2 * TRIG_FB - OUT_FRAC, ca.neg ^ sb.neg);
    p.y = round_out(d * ca.mag * cb.mag, 2 * TRIG_FB - OUT_FRAC, ca.neg ^ cb.neg);
    p.z = round_out(d * sa.mag, TRIG_FB - OUT_FRAC, sa.neg);
    pos_expected.push_back(p);
  endtask

  task automatic check_field(input string name, input logic signed [OUT_W-1:0] want,
                             input logic signed [OUT_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : drive_req
    move_t m;
    if (!rst_ni) begin
      req_ch.valid           <= 1'b0;
      req_ch.delta_azimuth   <= '0;
      req_ch.delta_elevation <= '0;
      req_ch.delta_distance  <= '0;
      tx_gap                 <= 0;
      tx_sent                <= '0;
      tx_idle_on             <= 1'b1;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        advance_camera(req_ch.delta_azimuth, req_ch.delta_elevation, req_ch.delta_distance);
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (tx_gap != 0) begin
          tx_gap       <= tx_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_moves.size() != 0) begin
          m = pending_moves.pop_front();
          req_ch.delta_azimuth   <= m.daz;
          req_ch.delta_elevation <= m.del;
          req_ch.delta_distance  <= m.ddist;
          req_ch.valid           <= 1'b1;
          tx_gap  <= tx_idle_on ? int'($urandom_range(0, 13)) : 0;
          tx_sent <= tx_sent + 16'd1;
          if (tx_sent[5:0] == 6'd63) begin
            tx_idle_on <= ($urandom_range(0, 3) != 0);
          end
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin : watch_res
    int   hold;
    pos_t want;
    if (!rst_ni) begin
      res_ch.ready <= 1'b0;
      rx_hold      <= 0;
      rx_seen      <= 0;
      rx_idle_on   <= 1'b1;
    end else begin
      hold = rx_hold;
      if (res_ch.valid && res_ch.ready) begin
        if (pos_expected.size() == 0) begin
          $display("%0t: position with no request pending, expected none, actual %0d %0d %0d",
                   $time, res_ch.pos_x, res_ch.pos_y, res_ch.pos_z);
          mismatches++;
        end else begin
          want = pos_expected.pop_front();
          check_field("pos_x", want.x, res_ch.pos_x);
          check_field("pos_y", want.y, res_ch.pos_y);
          check_field("pos_z", want.z, res_ch.pos_z);
        end
        rx_seen <= rx_seen + 1;
        // long stall so the core fills up and holds off requests
        if (rx_seen % 500 == 250) begin
          hold = 200;
        end else begin
          hold = rx_idle_on ? int'($urandom_range(0, 13)) : 0;
        end
        if (rx_seen % 64 == 63) begin
          rx_idle_on <= ($urandom_range(0, 3) != 0);
        end
      end else if (hold != 0) begin
        hold = hold - 1;
      end
      rx_hold      <= hold;
      res_ch.ready <= (hold == 0);
    end
  end

  task automatic push_move(input int daz, input int del, input int ddist);
    move_t m;
    m.daz   = FIELD_W'(daz);
    m.del   = FIELD_W'(del);
    m.ddist = FIELD_W'(ddist);
    pending_moves.push_back(m);
  endtask

  task automatic push_random(input int n);
    move_t m;
    for (int i = 0; i < n; i++) begin
      m.daz = $urandom_range(0, 1) ? FIELD_W'($urandom)
                                   : FIELD_W'($urandom_range(0, 24)) - 10'd12;
      m.del = $urandom_range(0, 1) ? FIELD_W'($urandom)
                                   : FIELD_W'($urandom_range(0, 24)) - 10'd12;
      case ($urandom_range(0, 4))
        0: m.ddist = '0;
        1: m.ddist = FIELD_W'($urandom);
        default: m.ddist = FIELD_W'($urandom_range(0, 64)) - 10'd32;
      endcase
      pending_moves.push_back(m);
    end
  endtask

  // sampled away from the active edge so the driver's updates have settled
  task automatic wait_drained();
    @(negedge clk_i);
    while (pending_moves.size() != 0 || req_ch.valid || pos_expected.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_bound(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(val);
    if (idx == CFG_MIN_DISTANCE) begin
      bound_lo = DIST_W'(val);
    end else begin
      bound_hi = DIST_W'(val);
    end
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_bounds(input int lo, input int hi);
    write_bound(CFG_MIN_DISTANCE, lo);
    write_bound(CFG_MAX_DISTANCE, hi);
  endtask

  initial begin
    int lo;
    rst_ni                 = 1'b0;
    cfg_we_i               = 1'b0;
    cfg_idx_i              = CFG_MIN_DISTANCE;
    cfg_data_i             = '0;
    req_ch.valid           = 1'b0;
    req_ch.delta_azimuth   = '0;
    req_ch.delta_elevation = '0;
    req_ch.delta_distance  = '0;
    res_ch.ready           = 1'b0;
    mismatches             = 0;
    bound_lo               = MIN_DISTANCE_RST;
    bound_hi               = MAX_DISTANCE_RST;
    az_deg                 = '0;
    el_deg                 = '0;
    cam_radius             = '0;
    for (int k = 0; k <= 90; k++) begin
      sine_rom[k] = taylor_sine(k);
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset bounds: boundary hits, negative distance, quadrant corners, wraps
    push_move(0, 0, 0);
    push_move(0, 0, 1);
    push_move(0, 0, -1);
    push_move(90, 0, 100);
    push_move(90, 90, 0);
    push_move(90, 90, 0);
    push_move(90, 90, 0);
    push_move(-512, -512, -512);
    push_move(511, 511, 511);
    push_move(1, 1, 399);
    push_move(0, 0, 1);
    push_move(0, 0, -498);
    push_move(0, 0, -497);
    push_move(45, 30, -1);
    push_move(-46, -301, 300);
    push_move(1, 1, 0);
    push_move(360, -360, 0);
    push_move(2, 2, 0);
    wait_drained();

    // widest window: largest distance and largest positions
    set_bounds(0, 1023);
    push_move(0, 0, 511);
    push_move(0, 0, 509);
    push_move(0, 0, 1);
    push_move(-2, -2, 0);
    push_move(0, 90, 0);
    push_move(0, 90, 0);
    push_move(90, 0, 0);
    push_move(180, 0, 0);
    push_move(0, 0, -512);
    push_move(0, 0, -510);
    push_random(300);
    wait_drained();

    // inverted bounds freeze the distance
    set_bounds(1023, 0);
    push_random(80);
    wait_drained();

    set_bounds(1, 500);
    push_random(350);
    wait_drained();

    set_bounds(200, 201);
    push_random(40);
    wait_drained();

    for (int p = 0; p < 4; p++) begin
      lo = $urandom_range(0, 400);
      set_bounds(lo, $urandom_range(lo + 50, 1023));
      push_random(175);
      wait_drained();
    end

    // sender pauses mid phase until every position is back
    set_bounds(0, 1023);
    push_random(175);
    wait_drained();
    push_random(175);
    wait_drained();

    if (mismatches == 0) begin
      $display("** orbit_camera_position_core: PASSED **");
    end else begin
      $display("** orbit_camera_position_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("** orbit_camera_position_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire

// ===== orbit_camera_position_core.f =====
rtl/core/ocp_pkg.sv
rtl/core/ocp_req_if.sv
rtl/core/ocp_res_if.sv
rtl/core/orbit_camera_position_core.sv
test/orbit_camera_position_core_tb.sv
